// ===== hw/rtl/srsc_pkg.sv =====
// ----------------------------------------------------------------------------
// srsc_pkg
// Shared types and constants of the snapshot record serializer.
// ----------------------------------------------------------------------------
package srsc_pkg;

    localparam int unsigned BUF_BYTES = 10;
    localparam int unsigned BUF_W     = BUF_BYTES * 8;
    localparam int unsigned CNT_W     = $clog2(BUF_BYTES + 1);

    localparam logic [63:0] CRC_POLY      = 64'h42F0_E1EB_A9EA_3693;
    localparam logic [31:0] VERSION_RESET = 32'd9;
    localparam logic [39:0] MAGIC_TEXT    = 40'h52_45_44_49_53;

    localparam logic [7:0] OP_SELECT_DB = 8'hFE;
    localparam logic [7:0] OP_EOF       = 8'hFF;
    localparam logic [7:0] OP_PAIR_TYPE = 8'h00;
    localparam logic [7:0] ENC_SHORT    = 8'hC0;
    localparam logic [7:0] ENC_INT8     = 8'hC3;
    localparam logic [7:0] ENC_INT16    = 8'hC2;
    localparam logic [7:0] ENC_INT32    = 8'hC1;
    localparam logic [7:0] ENC_INT64    = 8'hC4;
    localparam logic [7:0] LEN_32BIT    = 8'h02;
    localparam logic [1:0] LEN_14BIT    = 2'b01;

    typedef enum logic [2:0] {
        KIND_START   = 3'd0,
        KIND_SELECT  = 3'd1,
        KIND_RESIZE  = 3'd2,
        KIND_PAIR    = 3'd3,
        KIND_STR_HDR = 3'd4,
        KIND_DATA    = 3'd5,
        KIND_INTEGER = 3'd6,
        KIND_END     = 3'd7
    } kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
    } dp_status_t;

endpackage

// ===== hw/rtl/srsc_if.sv =====
// ----------------------------------------------------------------------------
// srsc_if
// Request channels of the snapshot record serializer.
// ----------------------------------------------------------------------------
interface srsc_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] length;
    logic signed [63:0] number;
    logic [7:0]  data_byte;

    modport source (output valid, kind, length, number, data_byte, input ready);
    modport sink   (input valid, kind, length, number, data_byte, output ready);
endinterface

interface srsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// ===== hw/rtl/srsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// srsc_ctrl
// Sequencer: takes a request, steps the byte buffer into the output register.
// ----------------------------------------------------------------------------
module srsc_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output srsc_pkg::dp_cmd_t      cmd,
    input  srsc_pkg::dp_status_t   status
);

    srsc_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srsc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            srsc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = srsc_pkg::ST_EMIT;
                end
            end
            srsc_pkg::ST_EMIT:
            begin
                // one byte per cycle whenever the output register frees up
                if (slot_free)
                begin
                    cmd.step       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.last)
                        state_next = srsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srsc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/srsc_dp.sv =====
// ----------------------------------------------------------------------------
// srsc_dp
// Datapath: record encoder, byte buffer, running crc and output register.
// ----------------------------------------------------------------------------
module srsc_dp
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [31:0]            cfg_data,
    input  logic [2:0]             kind,
    input  logic [31:0]            length,
    input  logic signed [63:0]     number,
    input  logic [7:0]             data_byte,
    input  srsc_pkg::dp_cmd_t      cmd,
    output srsc_pkg::dp_status_t   status,
    output logic [7:0]             out_byte,
    output logic                   last_byte
);

    typedef struct packed {
        logic [39:0] bytes;
        logic [2:0]  n;
    } len_enc_t;

    typedef struct packed {
        logic [srsc_pkg::BUF_W-1:0] bytes;
        logic [srsc_pkg::CNT_W-1:0] n;
    } rec_enc_t;

    function automatic len_enc_t enc_length(input logic [31:0] len);
        len_enc_t e;
        if (len < 32'd64)
        begin
            e.bytes = {len[7:0], 32'h0};
            e.n     = 3'd1;
        end
        else if (len < 32'd16384)
        begin
            e.bytes = {len[13:0], srsc_pkg::LEN_14BIT, 24'h0};
            e.n     = 3'd2;
        end
        else
        begin
            e.bytes = {srsc_pkg::LEN_32BIT, len};
            e.n     = 3'd5;
        end
        return e;
    endfunction

    function automatic logic [63:0] crc_byte(input logic [63:0] crc, input logic [7:0] b);
        logic [63:0] c;
        c = crc ^ {56'h0, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ srsc_pkg::CRC_POLY) : (c >> 1);
        return c;
    endfunction

    logic [31:0]                 version_reg;
    logic [63:0]                 crc_reg, crc_next;
    logic [srsc_pkg::BUF_W-1:0]  buf_reg, buf_next;
    logic [srsc_pkg::CNT_W-1:0]  remain_reg, remain_next;
    logic                        tail_reg, tail_next;
    logic                        first_reg, first_next;
    logic [7:0]                  out_byte_reg, out_byte_next;
    logic                        last_reg, last_next;

    len_enc_t                    len_e;
    rec_enc_t                    rec;
    logic [srsc_pkg::BUF_W-1:0]  len_wide;
    logic [63:0]                 crc_upd;
    logic [7:0]                  cur_byte;

    assign len_e    = enc_length(length);
    assign len_wide = {len_e.bytes, {(srsc_pkg::BUF_W - 40){1'b0}}};
    assign cur_byte = buf_reg[srsc_pkg::BUF_W-1 -: 8];
    assign crc_upd  = crc_byte(crc_reg, cur_byte);

    assign status.last = (remain_reg == srsc_pkg::CNT_W'(1));
    assign out_byte    = out_byte_reg;
    assign last_byte   = last_reg;

    // encoder: whole record left-aligned in the buffer, first byte on top
    always_comb
    begin
        rec.bytes = '0;
        rec.n     = srsc_pkg::CNT_W'(1);
        unique case (srsc_pkg::kind_t'(kind))
            srsc_pkg::KIND_START:
            begin
                rec.bytes = {srsc_pkg::MAGIC_TEXT, version_reg, 8'h0};
                rec.n     = srsc_pkg::CNT_W'(9);
            end
            srsc_pkg::KIND_SELECT:
            begin
                rec.bytes = {srsc_pkg::OP_SELECT_DB, len_e.bytes, 32'h0};
                rec.n     = srsc_pkg::CNT_W'(len_e.n) + srsc_pkg::CNT_W'(1);
            end
            srsc_pkg::KIND_RESIZE:
            begin
                rec.bytes = len_wide | (len_wide >> {len_e.n, 3'b000});
                rec.n     = srsc_pkg::CNT_W'({len_e.n, 1'b0});
            end
            srsc_pkg::KIND_PAIR:
            begin
                rec.bytes = {srsc_pkg::OP_PAIR_TYPE, 72'h0};
            end
            srsc_pkg::KIND_STR_HDR:
            begin
                if (length < 32'd64)
                    rec.bytes = {srsc_pkg::ENC_SHORT | {2'b00, length[5:0]}, 72'h0};
                else
                begin
                    rec.bytes = len_wide;
                    rec.n     = srsc_pkg::CNT_W'(len_e.n);
                end
            end
            srsc_pkg::KIND_DATA:
            begin
                rec.bytes = {data_byte, 72'h0};
            end
            srsc_pkg::KIND_INTEGER:
            begin
                if (!number[63] && number < 64'sd13)
                    rec.bytes = {srsc_pkg::ENC_SHORT | number[7:0], 72'h0};
                else if (number == {{56{number[7]}}, number[7:0]})
                begin
                    rec.bytes = {srsc_pkg::ENC_INT8, number[7:0], 64'h0};
                    rec.n     = srsc_pkg::CNT_W'(2);
                end
                else if (number == {{48{number[15]}}, number[15:0]})
                begin
                    rec.bytes = {srsc_pkg::ENC_INT16, number[15:0], 56'h0};
                    rec.n     = srsc_pkg::CNT_W'(3);
                end
                else if (number == {{32{number[31]}}, number[31:0]})
                begin
                    rec.bytes = {srsc_pkg::ENC_INT32, number[31:0], 40'h0};
                    rec.n     = srsc_pkg::CNT_W'(5);
                end
                else
                begin
                    rec.bytes = {srsc_pkg::ENC_INT64, number, 8'h0};
                    rec.n     = srsc_pkg::CNT_W'(9);
                end
            end
            srsc_pkg::KIND_END:
            begin
                // checksum bytes are loaded after the marker byte goes out
                rec.bytes = {srsc_pkg::OP_EOF, 72'h0};
                rec.n     = srsc_pkg::CNT_W'(9);
            end
            default:
            begin
                rec.bytes = '0;
            end
        endcase
    end

    always_comb
    begin
        crc_next      = crc_reg;
        buf_next      = buf_reg;
        remain_next   = remain_reg;
        tail_next     = tail_reg;
        first_next    = first_reg;
        out_byte_next = out_byte_reg;
        last_next     = last_reg;
        if (cmd.load)
        begin
            buf_next    = rec.bytes;
            remain_next = rec.n;
            tail_next   = (srsc_pkg::kind_t'(kind) == srsc_pkg::KIND_END);
            first_next  = 1'b1;
            if (srsc_pkg::kind_t'(kind) == srsc_pkg::KIND_START)
                crc_next = '0;
        end
        else if (cmd.step)
        begin
            out_byte_next = cur_byte;
            last_next     = status.last;
            remain_next   = remain_reg - srsc_pkg::CNT_W'(1);
            first_next    = 1'b0;
            buf_next      = buf_reg << 8;
            // checksum bytes themselves are not folded into the crc
            if (!tail_reg || first_reg)
                crc_next = crc_upd;
            if (tail_reg && first_reg)
                buf_next = {crc_upd, {(srsc_pkg::BUF_W - 64){1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= srsc_pkg::VERSION_RESET;
            crc_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                version_reg <= cfg_data;
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg      <= buf_next;
        remain_reg   <= remain_next;
        tail_reg     <= tail_next;
        first_reg    <= first_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

endmodule

// ===== hw/rtl/snapshot_record_serializer_crc64_unit.sv =====
// ----------------------------------------------------------------------------
// snapshot_record_serializer_crc64_unit
// Turns record requests into snapshot bytes with a running reflected crc-64.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  cmd       in   valid/ready    kind, length, number, data_byte
//  res       out  valid/ready    out_byte, last_byte
//  cfg       in   cfg_we         cfg_data (format version)
//
// a request is loaded into the byte buffer, then its bytes (1 to 10) step out one
// at a time; the single byte buffer and output register set the pace.
// the next request is taken while the last byte still waits in the output
// register. a stalled res channel holds the sequencer. reset clears the crc
// and sets the version to 9.
module snapshot_record_serializer_crc64_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    srsc_cmd_if.sink    cmd,
    srsc_byte_if.source res
);

    srsc_pkg::dp_cmd_t    dp_cmd;
    srsc_pkg::dp_status_t dp_status;

    srsc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

    srsc_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .kind      (cmd.kind),
        .length    (cmd.length),
        .number    (cmd.number),
        .data_byte (cmd.data_byte),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .out_byte  (res.out_byte),
        .last_byte (res.last_byte)
    );

endmodule

// ===== tb/sv/tb_snapshot_record_serializer_crc64_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_snapshot_record_serializer_crc64_unit
// Drives record requests into the serializer and checks every snapshot byte
// and its end-of-request flag against an encoder kept in the bench, which
// carries its own running crc-64 and copy of the version register.
// ----------------------------------------------------------------------------
module tb_snapshot_record_serializer_crc64_unit;

    localparam logic [63:0] CRC_MASK64  = 64'h42F0_E1EB_A9EA_3693;
    localparam logic [39:0] FILE_MAGIC  = 40'h52_45_44_49_53;
    localparam logic [7:0]  MARK_SELECT = 8'hFE;
    localparam logic [7:0]  MARK_EOF    = 8'hFF;
    localparam logic [7:0]  MARK_PAIR   = 8'h00;
    localparam logic [7:0]  INT_IMM     = 8'hC0;
    localparam logic [7:0]  INT8_TAG    = 8'hC3;
    localparam logic [7:0]  INT16_TAG   = 8'hC2;
    localparam logic [7:0]  INT32_TAG   = 8'hC1;
    localparam logic [7:0]  INT64_TAG   = 8'hC4;
    localparam logic [7:0]  LEN32_TAG   = 8'h02;

    localparam int unsigned MAX_WAIT    = 10;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned TAIL_CYCLES = 16;
    localparam int unsigned PHASE_RECS  = 46;

    typedef struct {
        srsc_pkg::kind_t kind;
        logic [31:0]     length;
        logic [63:0]     number;
        logic [7:0]      data_byte;
    } rec_req_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } snap_byte_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [31:0] cfg_data = '0;

    srsc_cmd_if  cmd_if ();
    srsc_byte_if res_if ();

    snapshot_record_serializer_crc64_unit u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd_if),
        .res      (res_if)
    );

    always #5 clk = ~clk;

    rec_req_t    pending_recs[$];
    snap_byte_t  expected_bytes[$];
    logic [7:0]  encoded_bytes[$];
    logic [63:0] crc_model     = '0;
    logic [31:0] version_model = 32'd9;

    int unsigned err_cnt    = 0;
    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;
    int unsigned hold_req   = 0;
    int unsigned hold_seen  = 0;
    logic        rdy_q      = 1'b0;
    bit          snd_calm   = 1'b0;
    bit          rcv_calm   = 1'b0;

    assign res_if.ready = rdy_q && (hold_left == 0);

    // ------------------------------------------------------------------
    // encoder
    // ------------------------------------------------------------------
    function automatic void put_byte(input logic [7:0] b, input bit counted);
        encoded_bytes.push_back(b);
        if (counted)
        begin
            crc_model = crc_model ^ {56'd0, b};
            for (int i = 0; i < 8; i++)
                crc_model = crc_model[0] ? (crc_model >> 1) ^ CRC_MASK64 : crc_model >> 1;
        end
    endfunction

    function automatic void put_be(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            put_byte(v[8*i +: 8], 1'b1);
    endfunction

    function automatic void put_length(input logic [31:0] len);
        if (len < 32'd64)
            put_byte(len[7:0], 1'b1);
        else if (len < 32'd16384)
            put_be({48'd0, len[13:0], 2'b01}, 2);
        else
        begin
            put_byte(LEN32_TAG, 1'b1);
            put_be({32'd0, len}, 4);
        end
    endfunction

    function automatic void encode_record(input rec_req_t r);
        logic [63:0] u;
        u = r.number;
        encoded_bytes.delete();
        case (r.kind)
            srsc_pkg::KIND_START:
            begin
                crc_model = '0;
                put_be({24'd0, FILE_MAGIC}, 5);
                put_be({32'd0, version_model}, 4);
            end
            srsc_pkg::KIND_SELECT:
            begin
                put_byte(MARK_SELECT, 1'b1);
                put_length(r.length);
            end
            srsc_pkg::KIND_RESIZE:
            begin
                put_length(r.length);
                put_length(r.length);
            end
            srsc_pkg::KIND_PAIR:
                put_byte(MARK_PAIR, 1'b1);
            srsc_pkg::KIND_STR_HDR:
            begin
                if (r.length < 32'd64)
                    put_byte(INT_IMM | r.length[7:0], 1'b1);
                else
                    put_length(r.length);
            end
            srsc_pkg::KIND_DATA:
                put_byte(r.data_byte, 1'b1);
            srsc_pkg::KIND_INTEGER:
            begin
                // size classes on the two's complement value
                if (u <= 64'd12)
                    put_byte(INT_IMM | u[7:0], 1'b1);
                else if (u + 64'h80 < 64'h100)
                begin
                    put_byte(INT8_TAG, 1'b1);
                    put_be(u, 1);
                end
                else if (u + 64'h8000 < 64'h1_0000)
                begin
                    put_byte(INT16_TAG, 1'b1);
                    put_be(u, 2);
                end
                else if (u + 64'h8000_0000 < 64'h1_0000_0000)
                begin
                    put_byte(INT32_TAG, 1'b1);
                    put_be(u, 4);
                end
                else
                begin
                    put_byte(INT64_TAG, 1'b1);
                    put_be(u, 8);
                end
            end
            srsc_pkg::KIND_END:
            begin
                // eof marker goes into the crc, the checksum bytes do not
                put_byte(MARK_EOF, 1'b1);
                for (int i = 7; i >= 0; i--)
                    put_byte(crc_model[8*i +: 8], 1'b0);
            end
        endcase
        foreach (encoded_bytes[i])
            expected_bytes.push_back('{value: encoded_bytes[i],
                                       last: (i == encoded_bytes.size() - 1)});
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
            version_model <= cfg_data;
    end

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_requests
        rec_req_t nxt;
        rec_req_t sent;
        if (rst_n)
        begin
            if (cmd_if.valid && cmd_if.ready)
            begin
                sent.kind      = srsc_pkg::kind_t'(cmd_if.kind);
                sent.length    = cmd_if.length;
                sent.number    = cmd_if.number;
                sent.data_byte = cmd_if.data_byte;
                encode_record(sent);
            end
            if (!cmd_if.valid || cmd_if.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left     <= gap_left - 1;
                    cmd_if.valid <= 1'b0;
                end
                else if (pending_recs.size() != 0)
                begin
                    nxt = pending_recs.pop_front();
                    cmd_if.valid     <= 1'b1;
                    cmd_if.kind      <= nxt.kind;
                    cmd_if.length    <= nxt.length;
                    cmd_if.number    <= nxt.number;
                    cmd_if.data_byte <= nxt.data_byte;
                    gap_left         <= snd_calm ? 0 : $urandom_range(0, MAX_WAIT);
                end
                else
                    cmd_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // byte monitor and receiver stalls
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_bytes
        snap_byte_t want;
        int unsigned w;
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected byte, expected none, got %02h last %0b",
                             $time, res_if.out_byte, res_if.last_byte);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (res_if.out_byte !== want.value || res_if.last_byte !== want.last)
                    begin
                        err_cnt++;
                        $display("%0t: byte mismatch, expected %02h last %0b, got %02h last %0b",
                                 $time, want.value, want.last, res_if.out_byte,
                                 res_if.last_byte);
                    end
                end
                w = rcv_calm ? 0 : $urandom_range(0, MAX_WAIT);
                stall_left <= w;
                rdy_q      <= (w == 0);
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                rdy_q      <= (stall_left == 1);
            end
            else
                rdy_q <= 1'b1;
        end
    end

    // long receiver hold-off, started on request from the sequence
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_req != hold_seen)
        begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_req;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic logic [31:0] rand_len();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 63);
            1:       return $urandom_range(64, 16383);
            2:       return $urandom_range(16384, 32'hFFFF_FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] rand_num();
        logic signed [63:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0)
            return 64'($urandom_range(0, 12));
        // arithmetic shift spreads values over every size class
        return v >>> $urandom_range(0, 63);
    endfunction

    function automatic rec_req_t make_req(input srsc_pkg::kind_t k);
        rec_req_t r;
        r.kind      = k;
        r.length    = rand_len();
        r.number    = rand_num();
        r.data_byte = 8'($urandom);
        return r;
    endfunction

    function automatic void queue_cmd(input srsc_pkg::kind_t k, input logic [63:0] val);
        rec_req_t r;
        r = make_req(k);
        if (k == srsc_pkg::KIND_SELECT || k == srsc_pkg::KIND_RESIZE ||
            k == srsc_pkg::KIND_STR_HDR)
            r.length = val[31:0];
        else if (k == srsc_pkg::KIND_INTEGER)
            r.number = val;
        else if (k == srsc_pkg::KIND_DATA)
            r.data_byte = val[7:0];
        pending_recs.push_back(r);
    endfunction

    function automatic void queue_string();
        rec_req_t r;
        r = make_req(srsc_pkg::KIND_STR_HDR);
        r.length = $urandom_range(0, 8);
        pending_recs.push_back(r);
        repeat (r.length)
            pending_recs.push_back(make_req(srsc_pkg::KIND_DATA));
    endfunction

    // well-formed snapshot: header, one db with its resize record, one to four key/value pairs, end
    function automatic int unsigned queue_file();
        int unsigned n0;
        n0 = pending_recs.size();
        pending_recs.push_back(make_req(srsc_pkg::KIND_START));
        pending_recs.push_back(make_req(srsc_pkg::KIND_SELECT));
        pending_recs.push_back(make_req(srsc_pkg::KIND_RESIZE));
        repeat ($urandom_range(1, 4))
        begin
            pending_recs.push_back(make_req(srsc_pkg::KIND_PAIR));
            queue_string();
            if ($urandom_range(0, 1) == 0)
                queue_string();
            else
                pending_recs.push_back(make_req(srsc_pkg::KIND_INTEGER));
        end
        pending_recs.push_back(make_req(srsc_pkg::KIND_END));
        return pending_recs.size() - n0;
    endfunction

    function automatic int unsigned queue_noise();
        int unsigned n;
        n = $urandom_range(1, 5);
        repeat (n)
            pending_recs.push_back(make_req(srsc_pkg::kind_t'($urandom_range(0, 7))));
        return n;
    endfunction

    function automatic void queue_random(input int unsigned count);
        int unsigned added;
        added = 0;
        while (added < count)
            added += ($urandom_range(0, 4) != 0) ? queue_file() : queue_noise();
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_recs.size() != 0 || cmd_if.valid || expected_bytes.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_version(input logic [31:0] v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        cmd_if.valid     = 1'b0;
        cmd_if.kind      = srsc_pkg::KIND_START;
        cmd_if.length    = '0;
        cmd_if.number    = '0;
        cmd_if.data_byte = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed pass at the reset version: length and integer boundaries
        queue_cmd(srsc_pkg::KIND_START, 64'd0);
        queue_cmd(srsc_pkg::KIND_SELECT, 64'd0);
        queue_cmd(srsc_pkg::KIND_SELECT, 64'd16383);
        queue_cmd(srsc_pkg::KIND_SELECT, 64'hFFFF_FFFF);
        queue_cmd(srsc_pkg::KIND_RESIZE, 64'd63);
        queue_cmd(srsc_pkg::KIND_RESIZE, 64'd64);
        queue_cmd(srsc_pkg::KIND_RESIZE, 64'd16384);
        queue_cmd(srsc_pkg::KIND_PAIR, 64'd0);
        queue_cmd(srsc_pkg::KIND_STR_HDR, 64'd63);
        queue_cmd(srsc_pkg::KIND_STR_HDR, 64'd64);
        queue_cmd(srsc_pkg::KIND_DATA, 64'h00);
        queue_cmd(srsc_pkg::KIND_DATA, 64'hFF);
        queue_cmd(srsc_pkg::KIND_INTEGER, 64'd12);
        queue_cmd(srsc_pkg::KIND_INTEGER, 64'd13);
        queue_cmd(srsc_pkg::KIND_INTEGER, -64'sd128);
        queue_cmd(srsc_pkg::KIND_INTEGER, 64'd128);
        queue_cmd(srsc_pkg::KIND_INTEGER, -64'sd32768);
        queue_cmd(srsc_pkg::KIND_INTEGER, 64'd32768);
        queue_cmd(srsc_pkg::KIND_INTEGER, -64'sd2147483648);
        queue_cmd(srsc_pkg::KIND_INTEGER, 64'd2147483648);
        queue_cmd(srsc_pkg::KIND_INTEGER, 64'h7FFF_FFFF_FFFF_FFFF);
        queue_cmd(srsc_pkg::KIND_INTEGER, 64'h8000_0000_0000_0000);
        queue_cmd(srsc_pkg::KIND_END, 64'd0);
        // crc keeps running after end until the next start
        queue_cmd(srsc_pkg::KIND_DATA, 64'hAB);
        queue_cmd(srsc_pkg::KIND_END, 64'd0);
        wait_idle();

        write_version(32'd0);
        queue_random(PHASE_RECS);
        wait_idle();

        // back-to-back requests against a long output stall
        write_version(32'hFFFF_FFFF);
        snd_calm = 1'b1;
        rcv_calm = 1'b1;
        hold_req++;
        queue_random(PHASE_RECS);
        wait_idle();

        write_version($urandom);
        snd_calm = 1'b1;
        rcv_calm = 1'b0;
        queue_random(PHASE_RECS);
        wait_idle();

        write_version(32'h8000_0001);
        snd_calm = 1'b0;
        rcv_calm = 1'b1;
        queue_random(PHASE_RECS);
        wait_idle();

        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
